@@ design/arec_pkg.sv @@
package arec_pkg;

   // Fixed widths of the request and result fields.
   localparam int ADDR_FIELD_BITS = 48;
   localparam int SIZE_FIELD_BITS = 40;
   localparam int FILE_BITS       = 32;
   localparam int LINE_BITS       = 31;
   localparam int COUNT_BITS      = 7;

   // Request codes.
   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_REPORT = 2'd2;

   // Result status codes.
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_DISABLED  = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [2:0] STAT_LEAK      = 3'd4;
   localparam logic [2:0] STAT_NO_LEAKS  = 3'd5;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic [ADDR_FIELD_BITS-1:0] address;
      logic [SIZE_FIELD_BITS-1:0] alloc_size;
      logic [FILE_BITS-1:0]       file_id;
      logic [LINE_BITS-1:0]       line_number;
   } arec_req_type;

   typedef struct packed {
      logic [2:0]                 status;
      logic [ADDR_FIELD_BITS-1:0] leak_address;
      logic [SIZE_FIELD_BITS-1:0] leak_size;
      logic [FILE_BITS-1:0]       leak_file_id;
      logic [LINE_BITS-1:0]       leak_line;
      logic [COUNT_BITS-1:0]      record_count;
      logic                       last;
   } arec_rsp_type;

endpackage

@@ design/arec_mem.sv @@
module arec_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IW-1:0]    wr_idx,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [IW-1:0]    rd_idx,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/allocation_record_table.sv @@
// Channel   Ports                              Handshake
// request   start, busy, req_data              taken when start is high and busy is low
// result    rsp_valid, rsp_data                shown for one cycle, cannot be held off
// config    csr_wr_en, csr_wr_data             written whenever csr_wr_en is high outside reset
//
// Short items (add, null remove, disabled, unknown, empty or full table) never raise
// busy and answer in the cycle after they are taken. A remove over n records checks one
// slot a cycle: a miss answers once the last slot is checked; a hit fetches the last
// record into the read register, then moves it into the hole and answers.
// A report keeps busy high until its last record is read and shows one result a cycle.
// Reset is synchronous and empties the table; the receiver cannot stall, so nothing waits.
module allocation_record_table #(
   parameter int TABLE_DEPTH  = 64,
   parameter int ADDRESS_BITS = 48,
   parameter int SIZE_BITS    = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  arec_pkg::arec_req_type req_data,
   output logic                   rsp_valid,
   output arec_pkg::arec_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);

   import arec_pkg::*;

   // Stored widths never exceed the widths of the fields that carry them.
   localparam int AW = (ADDRESS_BITS < ADDR_FIELD_BITS) ? ADDRESS_BITS : ADDR_FIELD_BITS;
   localparam int SW = (SIZE_BITS < SIZE_FIELD_BITS) ? SIZE_BITS : SIZE_FIELD_BITS;
   localparam int RW = AW + SW + FILE_BITS + LINE_BITS;
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_FETCH  = 5'b00100,
      S_MOVE   = 5'b01000,
      S_REPORT = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic          enable_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] key_ff, key_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          chk_valid_ff, chk_valid_in;
   logic [CW-1:0] chk_idx_ff, chk_idx_in;
   logic [IW-1:0] match_ff, match_in;
   logic          rsp_valid_ff, rsp_valid_in;
   arec_rsp_type  rsp_ff, rsp_in;

   logic                 wr_en;
   logic [IW-1:0]        wr_idx;
   logic [RW-1:0]        wr_data;
   logic [IW-1:0]        rd_idx;
   logic [RW-1:0]        rd_data;
   logic [AW-1:0]        rd_addr;
   logic [SW-1:0]        rd_size;
   logic [FILE_BITS-1:0] rd_file;
   logic [LINE_BITS-1:0] rd_line;
   logic [CW-1:0]        last_slot;
   logic                 issue_more;
   logic                 accept;

   arec_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (RW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   // A record is packed as address, size, file id and line, high to low.
   assign rd_line = rd_data[LINE_BITS-1:0];
   assign rd_file = rd_data[LINE_BITS+FILE_BITS-1:LINE_BITS];
   assign rd_size = rd_data[LINE_BITS+FILE_BITS+SW-1:LINE_BITS+FILE_BITS];
   assign rd_addr = rd_data[RW-1:LINE_BITS+FILE_BITS+SW];

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign last_slot  = count_ff - CW'(1);
   assign issue_more = (issue_ff < count_ff);

   // The single read port walks the table during a scan or report; while fetching it
   // reads the last record, which is about to fill the hole left by a removal.
   always_comb begin
      if (state_ff == S_FETCH) begin
         rd_idx = last_slot[IW-1:0];
      end else if (issue_more) begin
         rd_idx = issue_ff[IW-1:0];
      end else begin
         rd_idx = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      issue_in     = issue_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      match_in     = match_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_idx       = count_ff[IW-1:0];
      wr_data      = {req_data.address[AW-1:0], req_data.alloc_size[SW-1:0],
                      req_data.file_id, req_data.line_number};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in              = '0;
               rsp_in.last         = 1'b1;
               rsp_in.record_count = COUNT_BITS'(count_ff);
               rsp_in.status       = STAT_OK;
               rsp_valid_in        = 1'b1;
               if (!enable_ff) begin
                  rsp_in.status = STAT_DISABLED;
               end else begin
                  case (req_data.req_type)
                     REQ_ADD: begin
                        if (count_ff == CW'(TABLE_DEPTH)) begin
                           rsp_in.status = STAT_FULL;
                        end else begin
                           wr_en               = 1'b1;
                           count_in            = count_ff + CW'(1);
                           rsp_in.record_count = COUNT_BITS'(count_ff + CW'(1));
                        end
                     end
                     REQ_REMOVE: begin
                        // A null address is ignored; the key compare uses the
                        // stored width, but the null test sees the whole field.
                        if (req_data.address == '0) begin
                           rsp_in.status = STAT_OK;
                        end else if (count_ff == '0) begin
                           rsp_in.status = STAT_NOT_FOUND;
                        end else begin
                           rsp_valid_in = 1'b0;
                           key_in       = req_data.address[AW-1:0];
                           issue_in     = '0;
                           state_in     = S_SCAN;
                        end
                     end
                     REQ_REPORT: begin
                        if (count_ff == '0) begin
                           rsp_in.status = STAT_NO_LEAKS;
                        end else begin
                           rsp_valid_in = 1'b0;
                           issue_in     = '0;
                           state_in     = S_REPORT;
                        end
                     end
                     default: begin
                        rsp_in.status = STAT_OK;
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            if (issue_more) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff;
               issue_in     = issue_ff + CW'(1);
            end
            // One address compare per cycle against the slot read last cycle.
            if (chk_valid_ff) begin
               if (rd_addr == key_ff) begin
                  match_in     = chk_idx_ff[IW-1:0];
                  chk_valid_in = 1'b0;
                  state_in     = S_FETCH;
               end else if (chk_idx_ff == last_slot) begin
                  chk_valid_in        = 1'b0;
                  rsp_in              = '0;
                  rsp_in.status       = STAT_NOT_FOUND;
                  rsp_in.record_count = COUNT_BITS'(count_ff);
                  rsp_in.last         = 1'b1;
                  rsp_valid_in        = 1'b1;
                  state_in            = S_IDLE;
               end
            end
         end
         S_FETCH: begin
            state_in = S_MOVE;
         end
         S_MOVE: begin
            // The last record now sits in the read register; move it into the hole.
            wr_en               = 1'b1;
            wr_idx              = match_ff;
            wr_data             = rd_data;
            count_in            = last_slot;
            rsp_in              = '0;
            rsp_in.status       = STAT_OK;
            rsp_in.record_count = COUNT_BITS'(last_slot);
            rsp_in.last         = 1'b1;
            rsp_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end
         S_REPORT: begin
            if (issue_more) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff;
               issue_in     = issue_ff + CW'(1);
            end
            if (chk_valid_ff) begin
               rsp_in.status       = STAT_LEAK;
               rsp_in.leak_address = ADDR_FIELD_BITS'(rd_addr);
               rsp_in.leak_size    = SIZE_FIELD_BITS'(rd_size);
               rsp_in.leak_file_id = rd_file;
               rsp_in.leak_line    = rd_line;
               rsp_in.record_count = COUNT_BITS'(count_ff);
               rsp_in.last         = (chk_idx_ff == last_slot);
               rsp_valid_in        = 1'b1;
               if (chk_idx_ff == last_slot) begin
                  chk_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         enable_ff    <= 1'b0;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      match_ff   <= match_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The table never holds more records than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("record count exceeds table depth");

   // A hit finishes with one ok result and one record fewer.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |=> (rsp_valid_ff && rsp_ff.status == STAT_OK
                                && count_ff == $past(last_slot)))
      else $error("removal did not shrink the table");

   // While more results of a request are due, no new request may be taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> busy)
      else $error("intermediate result while idle");

   // With tracking off, a request is answered at once and leaves the table alone.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !enable_ff) |=> (rsp_valid_ff && rsp_ff.status == STAT_DISABLED
                                  && $stable(count_ff)))
      else $error("disabled request not answered as disabled");

endmodule
